### hw/rtl/wbbp_pkg.sv
// Shared constants, widths and types for the width-budget batch planner.
package wbbp_pkg;

    localparam int BATCH_LIMIT = 6;
    localparam int MAX_ITEMS   = 65536;

    localparam int TH_W    = 10;
    localparam int BW_W    = 12;
    localparam int BUDGET_W = 20;
    localparam int CROP_W  = 16;
    localparam int POS_W   = 17;
    localparam int BEGIN_W = 16;
    localparam int CNT_W   = $clog2(BATCH_LIMIT + 1);
    localparam int DVD_W   = TH_W + CROP_W;
    localparam int STEP_W  = $clog2(DVD_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = BUDGET_W;

    localparam int S_DATA_W = 2 * CROP_W;
    localparam int M_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BUDGET  = 2'd3;

    localparam logic [TH_W-1:0]     TH_RESET     = 10'd48;
    localparam logic [BW_W-1:0]     BW_RESET     = 12'd320;
    localparam logic [BW_W-1:0]     MW_RESET     = 12'd3200;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 20'd0;

    typedef struct packed {
        logic [BEGIN_W-1:0] batch_begin;
        logic [POS_W-1:0]   batch_stop;
        logic [BW_W-1:0]    widest_estimate;
        logic               run_last;
        logic               list_done;
    } wbbp_res_t;

    typedef struct packed {
        wbbp_res_t  slot_a;
        wbbp_res_t  slot_b;
        logic [1:0] n_res;
    } wbbp_plan_t;

endpackage

### hw/rtl/width_budget_batch_planner_unit.sv
// Top level: config registers, sequencer, divider, planner and result buffer.
//
//  port group   dir  contents
//  s_axis       in   tdata = {crop_height, crop_width}, tlast = last_item
//  m_axis       out  tdata = {widest_estimate, batch_stop, batch_begin}, tuser = run_last,
//                    tlast = list_done
//  cfg          in   cfg_we / cfg_index / cfg_wdata, write only
//
// Each crop goes from transfer to its results through load, multiply, 26 divider
// steps (one quotient bit each), clamp and plan.
// s_tready is high only while the sequencer is idle.
// Results go to a two-entry buffer; planning waits there until the buffer is empty,
// so the next crop can be taken and divided while earlier results drain.
// aresetn is synchronous; it restores register defaults and empties the open batch.
module width_budget_batch_planner_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wbbp_pkg::S_DATA_W-1:0]     s_tdata,   // crop_width, crop_height
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wbbp_pkg::M_DATA_W-1:0]     m_tdata,   // batch_begin, batch_stop,
                                                         // widest_estimate, zero pad
    output logic                              m_tuser,   // run_last
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [wbbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wbbp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import wbbp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_DIV   = 5'b00100,
        S_CLAMP = 5'b01000,
        S_PLAN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [TH_W-1:0]     th_reg;
    logic [BW_W-1:0]     bw_reg;
    logic [BW_W-1:0]     mw_reg;
    logic [BUDGET_W-1:0] budget_reg;

    logic [CROP_W-1:0] w_reg;
    logic [CROP_W-1:0] h_reg;
    logic              last_reg;
    logic [BW_W-1:0]   est_reg;

    wbbp_res_t  ob0_reg;
    wbbp_res_t  ob1_reg;
    logic [1:0] ob_cnt_reg;

    logic [TH_W-1:0]   th_eff;
    logic [CROP_W-1:0] ww;
    logic [CROP_W-1:0] hh;
    logic [BW_W-1:0]   bw_eff;
    logic [BW_W-1:0]   mw_eff;
    logic [DVD_W-1:0]  product;
    logic [DVD_W-1:0]  quotient;
    logic              div_done;
    logic              div_start;
    logic              commit;
    logic              pop;
    wbbp_plan_t        plan;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            th_reg     <= TH_RESET;
            bw_reg     <= BW_RESET;
            mw_reg     <= MW_RESET;
            budget_reg <= BUDGET_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TARGET_HEIGHT: th_reg     <= cfg_wdata[TH_W-1:0];
                CFG_BASE_WIDTH:    bw_reg     <= cfg_wdata[BW_W-1:0];
                CFG_MAX_WIDTH:     mw_reg     <= cfg_wdata[BW_W-1:0];
                CFG_WIDTH_BUDGET:  budget_reg <= cfg_wdata[BUDGET_W-1:0];
                default: ;
            endcase
        end
    end

    assign th_eff  = (th_reg == '0) ? TH_W'(1) : th_reg;
    assign ww      = (w_reg == '0) ? CROP_W'(1) : w_reg;
    assign hh      = (h_reg == '0) ? CROP_W'(1) : h_reg;
    assign bw_eff  = (bw_reg == '0) ? BW_W'(1) : bw_reg;
    assign mw_eff  = (mw_reg > bw_eff) ? mw_reg : bw_eff;
    assign product = {{CROP_W{1'b0}}, th_eff} * {{TH_W{1'b0}}, ww};

    assign s_tready  = (state_reg == S_IDLE);
    assign div_start = (state_reg == S_MUL);
    assign commit    = (state_reg == S_PLAN) && (ob_cnt_reg == 2'd0);
    assign pop       = m_tvalid && m_tready;

    wbbp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product),
        .divisor  (hh),
        .done     (div_done),
        .quotient (quotient)
    );

    wbbp_plan u_plan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (commit),
        .est     (est_reg),
        .last    (last_reg),
        .budget  (budget_reg),
        .plan    (plan)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_MUL;
            S_MUL:   state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_CLAMP;
            S_CLAMP: state_next = S_PLAN;
            S_PLAN:  if (ob_cnt_reg == 2'd0) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            w_reg    <= s_tdata[CROP_W-1:0];
            h_reg    <= s_tdata[2*CROP_W-1:CROP_W];
            last_reg <= s_tlast;
        end
        if (state_reg == S_CLAMP) begin
            if (quotient < {{(DVD_W-BW_W){1'b0}}, bw_eff}) begin
                est_reg <= bw_eff;
            end else if (quotient > {{(DVD_W-BW_W){1'b0}}, mw_eff}) begin
                est_reg <= mw_eff;
            end else begin
                est_reg <= quotient[BW_W-1:0];
            end
        end
    end

    // two-entry result buffer; loaded only when empty
    always_ff @(posedge aclk) begin
        if (commit) begin
            ob0_reg <= plan.slot_a;
            ob1_reg <= plan.slot_b;
        end else if (pop) begin
            ob0_reg <= ob1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_cnt_reg <= 2'd0;
        end else if (commit) begin
            ob_cnt_reg <= plan.n_res;
        end else if (pop) begin
            ob_cnt_reg <= ob_cnt_reg - 2'd1;
        end
    end

    assign m_tvalid = (ob_cnt_reg != 2'd0);
    assign m_tdata  = {{(M_DATA_W-BEGIN_W-POS_W-BW_W){1'b0}}, ob0_reg.widest_estimate,
                       ob0_reg.batch_stop, ob0_reg.batch_begin};
    assign m_tuser  = ob0_reg.run_last;
    assign m_tlast  = ob0_reg.list_done;

    a_buf_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        ob_cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide phase");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second crop taken while one is in flight");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("final batch of a list not marked last of its run");

endmodule

### hw/rtl/wbbp_div.sv
// Restoring divider, one quotient bit per cycle.
module wbbp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wbbp_pkg::DVD_W-1:0]    dividend,
    input  logic [wbbp_pkg::CROP_W-1:0]   divisor,
    output logic                          done,
    output logic [wbbp_pkg::DVD_W-1:0]    quotient
);
    import wbbp_pkg::*;

    logic [DVD_W-1:0]  qd_reg;
    logic [CROP_W-1:0] rem_reg;
    logic [CROP_W-1:0] dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [CROP_W:0] trial;
    logic [CROP_W:0] diff;
    logic            fits;

    assign trial = {rem_reg, qd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            qd_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            qd_reg  <= {qd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[CROP_W-1:0] : trial[CROP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule

### hw/rtl/wbbp_plan.sv
// Open-batch state and the close decisions for one crop.
module wbbp_plan (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            commit,
    input  logic [wbbp_pkg::BW_W-1:0]       est,
    input  logic                            last,
    input  logic [wbbp_pkg::BUDGET_W-1:0]   budget,
    output wbbp_pkg::wbbp_plan_t            plan
);
    import wbbp_pkg::*;

    logic [POS_W-1:0] open_start_reg, open_start_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [CNT_W-1:0] open_count_reg, open_count_next;
    logic [BW_W-1:0]  open_widest_reg, open_widest_next;

    logic [BW_W-1:0]            nw;
    logic [CNT_W-1:0]           cnt_inc;
    logic [BW_W+CNT_W-1:0]      prod;
    logic                       close_first;
    logic                       close_second;
    logic [CNT_W-1:0]           cnt_a;
    logic [POS_W-1:0]           start_a;
    logic [BW_W-1:0]            widest_a;
    logic [BW_W-1:0]            widest_b;
    logic [CNT_W-1:0]           cnt_b;
    logic [POS_W-1:0]           pos_b;
    wbbp_res_t                  first_res;
    wbbp_res_t                  second_res;

    always_comb begin
        nw      = (open_widest_reg > est) ? open_widest_reg : est;
        cnt_inc = open_count_reg + CNT_W'(1);
        prod    = {{CNT_W{1'b0}}, nw} * {{BW_W{1'b0}}, cnt_inc};

        close_first = (open_count_reg >= CNT_W'(BATCH_LIMIT)) ||
                      ((open_count_reg != '0) && (budget != '0) &&
                       ({{(BUDGET_W-BW_W-CNT_W){1'b0}}, prod} > budget));

        // the first result always describes the batch as it stood
        cnt_a    = close_first ? '0 : open_count_reg;
        start_a  = (cnt_a == '0) ? position_reg : open_start_reg;
        widest_a = (cnt_a == '0) ? '0 : open_widest_reg;
        widest_b = (est > widest_a) ? est : widest_a;
        cnt_b    = cnt_a + CNT_W'(1);
        pos_b    = (position_reg < POS_W'(MAX_ITEMS)) ? position_reg + POS_W'(1)
                                                       : position_reg;
        close_second = (cnt_b >= CNT_W'(BATCH_LIMIT)) || last;

        first_res.batch_begin     = open_start_reg[BEGIN_W-1:0];
        first_res.batch_stop      = position_reg;
        first_res.widest_estimate = open_widest_reg;
        first_res.run_last        = !close_second;
        first_res.list_done       = 1'b0;

        second_res.batch_begin     = start_a[BEGIN_W-1:0];
        second_res.batch_stop      = pos_b;
        second_res.widest_estimate = widest_b;
        second_res.run_last        = 1'b1;
        second_res.list_done       = last;

        plan.slot_a = close_first ? first_res : second_res;
        plan.slot_b = second_res;
        plan.n_res  = {1'b0, close_first} + {1'b0, close_second};

        if (last) begin
            open_start_next  = '0;
            position_next    = '0;
            open_count_next  = '0;
            open_widest_next = '0;
        end else if (close_second) begin
            open_start_next  = pos_b;
            position_next    = pos_b;
            open_count_next  = '0;
            open_widest_next = '0;
        end else begin
            open_start_next  = start_a;
            position_next    = pos_b;
            open_count_next  = cnt_b;
            open_widest_next = widest_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_start_reg  <= '0;
            position_reg    <= '0;
            open_count_reg  <= '0;
            open_widest_reg <= '0;
        end else if (commit) begin
            open_start_reg  <= open_start_next;
            position_reg    <= position_next;
            open_count_reg  <= open_count_next;
            open_widest_reg <= open_widest_next;
        end
    end

endmodule
